@@ rtl/core/swd_pkg.sv @@
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types and constants for the sync word deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package swd_pkg;

	localparam int SYNC_LEN_DEF = 2;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [2:0] EV_PAYLOAD = 3'd0;
	localparam logic [2:0] EV_START   = 3'd1;
	localparam logic [2:0] EV_ACK     = 3'd2;
	localparam logic [2:0] EV_BADID   = 3'd3;
	localparam logic [2:0] EV_BADDATA = 3'd4;

	localparam logic CFG_SYNC_PATTERN = 1'b0;
	localparam logic CFG_SYNC_ACK     = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  mtype;
		logic [7:0]  val;
		logic [7:0]  exp_id;
		logic [15:0] len;
		logic        pend;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/core/swd_core.sv @@
// ----------------------------------------------------------------------------
// swd_core
// Deframer state machine: hunt, header, payload; makes up to two results
// per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_core #(
	parameter int SYNC_LEN = swd_pkg::SYNC_LEN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [7:0]    b,
	input  wire logic [31:0]   sync_pattern,
	input  wire logic [7:0]    sync_ack_type,
	output swd_pkg::res_t      r0,
	output swd_pkg::res_t      r1,
	output logic [1:0]         nres
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [2:0] SYNC_LEN_W = 3'(SYNC_LEN);

	logic [1:0]  phase_q, phase_d;
	logic [1:0]  prog_q, prog_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  lenhi_q, lenhi_d;
	logic [15:0] left_q, left_d;
	logic        skip_q, skip_d;
	logic [7:0]  nid_q, nid_d;
	logic        conn_q, conn_d;
	logic        mis_q, mis_d;

	logic [15:0] hdr_len;
	logic [7:0]  nid_inc;
	logic [7:0]  want;
	logic [2:0]  prog_inc;
	logic        last_pay;
	logic        to_hunt;

	always_comb begin
		phase_d  = phase_q;
		prog_d   = prog_q;
		hcnt_d   = hcnt_q;
		type_d   = type_q;
		id_d     = id_q;
		lenhi_d  = lenhi_q;
		left_d   = left_q;
		skip_d   = skip_q;
		nid_d    = nid_q;
		conn_d   = conn_q;
		mis_d    = mis_q;
		r0       = '0;
		r1       = '0;
		nres     = 2'd0;
		to_hunt  = 1'b0;
		hdr_len  = {lenhi_q, b};
		nid_inc  = nid_q + 8'd1;
		want     = sync_pattern[{prog_q, 3'b000} +: 8];
		prog_inc = {1'b0, prog_q} + 3'd1;
		last_pay = (left_q <= 16'd1);

		case (phase_q)
			PH_HEADER: begin
				case (hcnt_q)
					2'd0: begin
						type_d = b;
						hcnt_d = 2'd1;
					end
					2'd1: begin
						id_d   = b;
						hcnt_d = 2'd2;
					end
					2'd2: begin
						lenhi_d = b;
						hcnt_d  = 2'd3;
					end
					default: begin
						hcnt_d = 2'd0;
						left_d = hdr_len;
						if (!conn_q && type_q != sync_ack_type) begin
							if (hdr_len == 16'd0) begin
								to_hunt = 1'b1;
							end else begin
								phase_d = PH_PAYLOAD;
								skip_d  = 1'b1;
							end
						end else if (id_q != 8'd0 && id_q != nid_q) begin
							r0.kind   = swd_pkg::EV_BADID;
							r0.val    = id_q;
							r0.exp_id = nid_q;
							nres      = 2'd1;
							to_hunt   = 1'b1;
						end else begin
							if (id_q != 8'd0) begin
								r0.kind  = swd_pkg::EV_ACK;
								r0.val   = id_q;
								r1.kind  = swd_pkg::EV_START;
								r1.mtype = type_q;
								r1.len   = hdr_len;
								nres     = 2'd2;
								nid_d    = (nid_inc == 8'd0) ? 8'd1 : nid_inc;
							end else begin
								r0.kind  = swd_pkg::EV_START;
								r0.mtype = type_q;
								r0.len   = hdr_len;
								nres     = 2'd1;
							end
							if (type_q == sync_ack_type) begin
								conn_d = 1'b1;
							end
							if (hdr_len == 16'd0) begin
								to_hunt = 1'b1;
							end else begin
								phase_d = PH_PAYLOAD;
								skip_d  = 1'b0;
							end
						end
					end
				endcase
			end
			PH_PAYLOAD: begin
				if (!skip_q) begin
					r0.kind  = swd_pkg::EV_PAYLOAD;
					r0.mtype = type_q;
					r0.val   = b;
					r0.pend  = last_pay;
					nres     = 2'd1;
				end
				left_d = last_pay ? 16'd0 : left_q - 16'd1;
				if (last_pay) begin
					to_hunt = 1'b1;
				end
			end
			default: begin
				if (b == want) begin
					if (prog_inc >= SYNC_LEN_W) begin
						phase_d = PH_HEADER;
						prog_d  = 2'd0;
						hcnt_d  = 2'd0;
						mis_d   = 1'b0;
					end else begin
						prog_d = prog_inc[1:0];
					end
				end else begin
					prog_d = 2'd0;
					if (!mis_q) begin
						mis_d   = 1'b1;
						r0.kind = swd_pkg::EV_BADDATA;
						nres    = 2'd1;
					end
				end
			end
		endcase

		if (to_hunt) begin
			phase_d = PH_HUNT;
			prog_d  = 2'd0;
			hcnt_d  = 2'd0;
			skip_d  = 1'b0;
		end

		if (nres == 2'd1) begin
			r0.last = 1'b1;
		end
		if (nres == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			prog_q  <= 2'd0;
			hcnt_q  <= 2'd0;
			type_q  <= 8'd0;
			id_q    <= 8'd0;
			lenhi_q <= 8'd0;
			left_q  <= 16'd0;
			skip_q  <= 1'b0;
			nid_q   <= 8'd1;
			conn_q  <= 1'b0;
			mis_q   <= 1'b0;
		end else if (go) begin
			phase_q <= phase_d;
			prog_q  <= prog_d;
			hcnt_q  <= hcnt_d;
			type_q  <= type_d;
			id_q    <= id_d;
			lenhi_q <= lenhi_d;
			left_q  <= left_d;
			skip_q  <= skip_d;
			nid_q   <= nid_d;
			conn_q  <= conn_d;
			mis_q   <= mis_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/swd_queue.sv @@
// ----------------------------------------------------------------------------
// swd_queue
// Result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire swd_pkg::res_t r0,
	input  wire swd_pkg::res_t r1,
	input  wire logic [1:0]    npush,
	input  wire logic          pop,
	output logic               room,
	output logic               nonempty,
	output swd_pkg::res_t      head
);

	localparam int CW = swd_pkg::QAW + 1;

	swd_pkg::res_t mem_q [swd_pkg::QDEPTH];
	logic [swd_pkg::QAW-1:0] rd_q, wr_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           cnt_left;

	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];
	assign cnt_left = cnt_q - CW'(pop);
	assign room     = (cnt_left <= CW'(swd_pkg::QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (npush != 2'd0) begin
			mem_q[wr_q] <= r0;
		end
		if (npush == 2'd2) begin
			mem_q[wr_q + swd_pkg::QAW'(1)] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= rd_q + swd_pkg::QAW'(1);
			end
			wr_q  <= wr_q + swd_pkg::QAW'(npush);
			cnt_q <= cnt_left + CW'(npush);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sync_word_deframer_with_sequence_ack.sv @@
// ----------------------------------------------------------------------------
// sync_word_deframer_with_sequence_ack
// Byte stream deframer with sync word hunt, header decode and packet-id ack.
//
// Input channel: in_valid/in_stall with rx_byte, one received byte a request.
// Output channel: out_valid/out_stall with the event fields; a byte gives
// zero, one or two events, last_of_run marks the last one of a byte.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
// sync_pattern (0) or sync_ack_type (1), cfg_data carries the value.
// Path: an accepted byte is held in the input register, and its events are
// written into the result queue once it has room for two; the first then
// shows from the queue head. Throughput: one byte a cycle while the queue keeps
// two free slots; bytes that make two events are limited by the one-event-
// per-cycle output port.
// Reset: clears the control registers, the hunt state and the queue; next id is 1.
// Stall: a stalled output holds its event; once the queue cannot take two
// more events the input register holds and in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_deframer_with_sequence_ack #(
	parameter int SYNC_LEN = swd_pkg::SYNC_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       event_kind,
	output logic [7:0]       message_type,
	output logic [7:0]       byte_value,
	output logic [7:0]       expected_id,
	output logic [15:0]      payload_length,
	output logic             payload_end,
	output logic             last_of_run,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [31:0]   sync_pattern_q;
	logic [7:0]    sync_ack_type_q;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          go;
	logic          room;
	logic          pop;
	logic [1:0]    nres;
	swd_pkg::res_t r0, r1, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q  <= 32'd0;
			sync_ack_type_q <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				swd_pkg::CFG_SYNC_PATTERN: sync_pattern_q  <= cfg_data;
				swd_pkg::CFG_SYNC_ACK:     sync_ack_type_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign go       = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	swd_core #(
		.SYNC_LEN(SYNC_LEN)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.b            (byte_s1),
		.sync_pattern (sync_pattern_q),
		.sync_ack_type(sync_ack_type_q),
		.r0           (r0),
		.r1           (r1),
		.nres         (nres)
	);

	assign pop = out_valid && !out_stall;

	swd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.r0      (r0),
		.r1      (r1),
		.npush   (go ? nres : 2'd0),
		.pop     (pop),
		.room    (room),
		.nonempty(out_valid),
		.head    (head)
	);

	assign event_kind     = head.kind;
	assign message_type   = head.mtype;
	assign byte_value     = head.val;
	assign expected_id    = head.exp_id;
	assign payload_length = head.len;
	assign payload_end    = head.pend;
	assign last_of_run    = head.last;

endmodule

`default_nettype wire

@@ rtl/core/swd_chk.sv @@
// ----------------------------------------------------------------------------
// swd_chk
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  event_kind,
	input wire logic [7:0]  byte_value,
	input wire logic [7:0]  expected_id,
	input wire logic        payload_end
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output request dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(event_kind) && $stable(byte_value))
		else $error("output request changed while stalled");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_end |-> event_kind == swd_pkg::EV_PAYLOAD)
		else $error("payload_end on a non-payload event");

	a_badid_exp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == swd_pkg::EV_BADID |-> expected_id != 8'd0)
		else $error("invalid-id event with zero expected id");

	a_badid_diff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == swd_pkg::EV_BADID |-> byte_value != expected_id)
		else $error("invalid-id event reports a matching id");

endmodule

bind sync_word_deframer_with_sequence_ack swd_chk u_swd_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_kind (event_kind),
	.byte_value (byte_value),
	.expected_id(expected_id),
	.payload_end(payload_end)
);

`default_nettype wire
